// ===== sv/ptt_pkg.sv =====
// Package: types, constants and widths shared by the page table translator.
`timescale 1ns / 1ps
package ptt_pkg;

  localparam int PAGE_BYTES  = 128;
  localparam int FRAME_COUNT = 128;
  localparam int TABLE_DEPTH = 128;

  localparam int VADDR_W  = 32;
  localparam int PADDR_W  = 14;
  localparam int FRAME_W  = 8;
  localparam int CFG_W    = 8;
  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int VPN_W    = VADDR_W - PAGE_BITS;
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int PA_RAW_W = FRAME_W + PAGE_BITS;
  localparam int PA_EXT_W = (PA_RAW_W > PADDR_W) ? PA_RAW_W : PADDR_W;

  localparam logic [FRAME_W-1:0] FRAME_UNASSIGNED = '1;
  localparam logic [FRAME_W-1:0] FRAME_LIMIT      = FRAME_W'(FRAME_COUNT);

  typedef enum logic [1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_WRITE     = 2'd1,
    FUNC_READ      = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    EXC_NONE      = 2'd0,
    EXC_ADDRESS   = 2'd1,
    EXC_READ_ONLY = 2'd2,
    EXC_BUS       = 2'd3
  } exc_t;

  typedef struct packed {
    func_t                func;
    logic [VADDR_W-1:0]   vaddr;
    logic                 is_write;
    logic [IDX_W-1:0]     entry_page;
    logic [FRAME_W-1:0]   entry_frame;
    logic                 entry_valid;
    logic                 entry_read_only;
  } in_item_t;

  typedef struct packed {
    logic [PADDR_W-1:0]   paddr;
    exc_t                 exception;
    logic [FRAME_W-1:0]   out_frame;
    logic                 out_valid;
    logic                 out_read_only;
    logic                 out_use;
    logic                 out_dirty;
  } out_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               valid;
    logic               read_only;
    logic               use_bit;
    logic               dirty;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    frame: FRAME_UNASSIGNED, valid: 1'b0, read_only: 1'b0, use_bit: 1'b0, dirty: 1'b0
  };

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

// ===== sv/ptt_table.sv =====
// Page table entry RAM: registered read, per-entry written flags, write-to-read bypass.
`timescale 1ns / 1ps
module ptt_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [ptt_pkg::IDX_W-1:0] rd_addr,
  input  ptt_pkg::tbl_wr_t      wr,
  output ptt_pkg::entry_t       rd_entry
);
  import ptt_pkg::*;

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_q_r;
  entry_t                 fwd_data_r;
  logic                   fwd_hit_r;
  logic                   init_hit_r;
  logic [TABLE_DEPTH-1:0] init_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= '0;
      fwd_hit_r  <= 1'b0;
      init_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        init_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_hit_r  <= wr.en && (wr.addr == rd_addr);
        init_hit_r <= init_r[rd_addr];
      end
    end
  end

  // entries never written read as unassigned
  assign rd_entry = fwd_hit_r  ? fwd_data_r :
                    init_hit_r ? rd_q_r     : ENTRY_RESET;

endmodule

// ===== sv/page_table_translate.sv =====
// Top level of the single-level page table translator.
//
// Input channel (in_valid/in_ready/in_item) carries one item: translate a
// virtual address, write a page entry, or read a page entry back. Each item
// gives exactly one result on the output channel (out_valid/out_ready/out_item).
// The cfg channel (cfg_valid/cfg_ready/cfg_data) sets the page count of the
// current address space; cfg_ready is always high, write it only while idle.
//
// A result passes through the stage-1 register and then the result register. The block
// takes one item per cycle while the receiver does not stall: the entry RAM is read
// at acceptance and written back as the item leaves stage 1, with a write-to-read
// bypass for back-to-back items that hit the same page.
//
// When the receiver stalls, the result register holds and in_ready drops; no
// item is lost. Reset clears the page count and marks every entry as never
// written, so it reads as frame 255 with all flags clear; no clearing pass.
`timescale 1ns / 1ps
module page_table_translate (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ptt_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ptt_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ptt_pkg::CFG_W-1:0] cfg_data
);
  import ptt_pkg::*;

  typedef struct packed {
    func_t                func;
    logic                 is_write;
    logic                 addr_err;
    logic [IDX_W-1:0]     page;
    logic [PAGE_BITS-1:0] off;
    logic [FRAME_W-1:0]   entry_frame;
    logic                 entry_valid;
    logic                 entry_read_only;
  } s1_t;

  logic [CFG_W-1:0] page_count_r;
  logic             s1_valid_r;
  s1_t              s1_r;
  s1_t              s1_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        out_nxt;
  logic             advance;
  logic             in_fire;
  logic [VPN_W-1:0] vpn;
  tbl_wr_t          tbl_wr;
  entry_t           entry;
  entry_t           upd;
  logic [PA_EXT_W-1:0] pa_ext;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      page_count_r <= cfg_data;
    end
  end

  // decode
  always_comb begin
    vpn                    = in_item.vaddr[VADDR_W-1:PAGE_BITS];
    s1_nxt.func            = in_item.func;
    s1_nxt.is_write        = in_item.is_write;
    s1_nxt.addr_err        = (vpn >= VPN_W'(page_count_r)) ||
                             (vpn >= VPN_W'(TABLE_DEPTH));
    s1_nxt.page            = (in_item.func == FUNC_TRANSLATE) ? vpn[IDX_W-1:0]
                                                              : in_item.entry_page;
    s1_nxt.off             = in_item.vaddr[PAGE_BITS-1:0];
    s1_nxt.entry_frame     = in_item.entry_frame;
    s1_nxt.entry_valid     = in_item.entry_valid;
    s1_nxt.entry_read_only = in_item.entry_read_only;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  ptt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (s1_nxt.page),
    .wr       (tbl_wr),
    .rd_entry (entry)
  );

  // check, update and report
  always_comb begin
    out_nxt     = '0;
    upd         = entry;
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = s1_r.page;
    pa_ext      = PA_EXT_W'({entry.frame, s1_r.off});
    case (s1_r.func)
      FUNC_TRANSLATE: begin
        if (s1_r.addr_err) begin
          out_nxt.exception = EXC_ADDRESS;
        end else if (s1_r.is_write && entry.read_only) begin
          out_nxt.exception = EXC_READ_ONLY;
        end else if (entry.frame >= FRAME_LIMIT) begin
          out_nxt.exception = EXC_BUS;
        end else begin
          upd.use_bit       = 1'b1;
          upd.dirty         = entry.dirty || s1_r.is_write;
          tbl_wr.en         = 1'b1;
          out_nxt.paddr     = pa_ext[PADDR_W-1:0];
          out_nxt.exception = EXC_NONE;
        end
      end
      FUNC_WRITE: begin
        upd.frame     = s1_r.entry_frame;
        upd.valid     = s1_r.entry_valid;
        upd.read_only = s1_r.entry_read_only;
        upd.use_bit   = 1'b0;
        upd.dirty     = 1'b0;
        tbl_wr.en     = 1'b1;
      end
      FUNC_READ: begin
      end
      default: begin
      end
    endcase
    if ((s1_r.func == FUNC_WRITE) || (s1_r.func == FUNC_READ) ||
        ((s1_r.func == FUNC_TRANSLATE) && !s1_r.addr_err)) begin
      out_nxt.out_frame     = upd.frame;
      out_nxt.out_valid     = upd.valid;
      out_nxt.out_read_only = upd.read_only;
      out_nxt.out_use       = upd.use_bit;
      out_nxt.out_dirty     = upd.dirty;
    end
    tbl_wr.data = upd;
    tbl_wr.en   = tbl_wr.en && s1_valid_r && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_item_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_wr_only_on_retire: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> (s1_valid_r && advance))
    else $error("table written without a retiring item");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item missing from stage 1");

  a_result_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without an item in flight");

  a_fault_no_paddr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.exception != EXC_NONE)) |-> (out_item_r.paddr == '0))
    else $error("faulting translate returned an address");

  a_addr_err_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.exception == EXC_ADDRESS)) |->
      ((out_item_r.out_frame == '0) && !out_item_r.out_use && !out_item_r.out_dirty))
    else $error("address error reported entry data");
`endif

endmodule
